/* design/bfdh_pkg.sv */
// ---------------------------------------------------------------------------
// bfdh_pkg
// Shared constants and types for the double-hashing bloom filter.
// ---------------------------------------------------------------------------
package bfdh_pkg;

   localparam int STORE_BITS  = 8192;
   localparam int STORE_BYTES = (STORE_BITS + 7) / 8;
   localparam int BYTE_AW     = $clog2(STORE_BYTES);

   localparam int CMD_W    = 2;
   localparam int HASH_W   = 32;
   localparam int FILTER_W = 14;
   localparam int PROBE_W  = 6;
   localparam int FILL_W   = 7;
   localparam int COUNT_W  = 14;
   localparam int CSR_W    = 14;
   localparam int CSR_IDX_W = 2;
   localparam int SAT_W    = FILTER_W + FILL_W;

   localparam logic [HASH_W-1:0] STEP_DEFAULT = 32'h9E37_79B9;
   localparam int PERCENT = 100;

   // remainder unit retires two dividend bits per cycle
   localparam int DIV_STEPS = HASH_W / 2;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_LIMIT  = 2'd2;

   localparam logic [FILTER_W-1:0] FILTER_BITS_RESET = 14'd8192;
   localparam logic [PROBE_W-1:0]  PROBE_COUNT_RESET = 6'd3;
   localparam logic [FILL_W-1:0]   FILL_LIMIT_RESET  = 7'd50;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

/* design/bfdh_ram.sv */
// ---------------------------------------------------------------------------
// bfdh_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module bfdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bloom_filter_double_hashing.sv */
// An add or query with p probes runs its probes in turn after acceptance (a query
//   may finish at its first clear bit); each probe passes through the
//   two-bit-per-cycle remainder unit, then one RAM read and one update.
// A new item is taken only once the last one has finished and the block is back in idle.
// A clear sweeps the 1024-word bit store one word a cycle, then gives its result.
// Reset runs the same sweep with req_stall high; csr writes are taken.
// ---------------------------------------------------------------------------
// bloom_filter_double_hashing
// Bloom filter over a RAM bit store, probes from double hashing with a
// quadratic term, ones count and saturation flag per result.
// ---------------------------------------------------------------------------
module bloom_filter_double_hashing (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bfdh_pkg::CMD_W-1:0]          req_command,
   input  logic [bfdh_pkg::HASH_W-1:0]         req_first_hash,
   input  logic [bfdh_pkg::HASH_W-1:0]         req_second_hash,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_present,
   output logic                                rsp_saturated,
   output logic [bfdh_pkg::COUNT_W-1:0]        rsp_set_bit_count,
   input  logic                                csr_wr_en,
   input  logic [bfdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfdh_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int FW = bfdh_pkg::FILTER_W;
   localparam int HW = bfdh_pkg::HASH_W;

   // control
   bfdh_pkg::state_type               state_ff, state_in;
   logic [FW-1:0]                     filter_bits_ff, filter_bits_in;
   logic [bfdh_pkg::PROBE_W-1:0]      probe_count_ff, probe_count_in;
   logic [bfdh_pkg::FILL_W-1:0]       fill_limit_ff, fill_limit_in;
   logic [bfdh_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [bfdh_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [bfdh_pkg::BYTE_AW-1:0]      sweep_addr_ff, sweep_addr_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [FW-1:0]                     mod_ff, mod_in;
   logic [HW-1:0]                     acc_ff, acc_in;
   logic [HW-1:0]                     step_ff, step_in;
   logic [HW-1:0]                     dividend_ff, dividend_in;
   logic [FW-1:0]                     rem_ff, rem_in;
   logic [bfdh_pkg::DIV_CW-1:0]       div_cnt_ff, div_cnt_in;
   logic [bfdh_pkg::PROBE_W-1:0]      probe_idx_ff, probe_idx_in;
   logic                              present_ff, present_in;
   logic                              rsp_present_ff, rsp_present_in;
   logic                              rsp_saturated_ff, rsp_saturated_in;
   logic [bfdh_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // RAM port
   logic                              ram_wr_en;
   logic [bfdh_pkg::BYTE_AW-1:0]      ram_wr_addr;
   logic [7:0]                        ram_wr_data;
   logic                              ram_rd_en;
   logic [bfdh_pkg::BYTE_AW-1:0]      ram_rd_addr;
   logic [7:0]                        ram_rd_data;

   logic [FW-1:0]                     active_bits;
   logic [HW-1:0]                     step_hash;
   logic                              probing_on;
   logic [FW-1:0]                     rem_half;
   logic                              bit_hit;
   logic [HW-1:0]                     acc_next;
   logic [bfdh_pkg::SAT_W-1:0]        fill_lhs;
   logic [bfdh_pkg::SAT_W-1:0]        fill_rhs;

   function automatic logic [FW-1:0] rem_step(input logic [FW-1:0] r,
                                              input logic b,
                                              input logic [FW-1:0] m);
      logic [FW:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[FW-1:0];
   endfunction

   bfdh_ram #(
      .WIDTH (8),
      .DEPTH (bfdh_pkg::STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign active_bits = (filter_bits_ff > FW'(bfdh_pkg::STORE_BITS)) ?
                        FW'(bfdh_pkg::STORE_BITS) : filter_bits_ff;
   assign step_hash   = (req_second_hash == '0) ? bfdh_pkg::STEP_DEFAULT : req_second_hash;
   assign probing_on  = (active_bits != '0) && (probe_count_ff != '0);
   assign rem_half    = rem_step(rem_ff, dividend_ff[HW-1], mod_ff);
   assign bit_hit     = ram_rd_data[rem_ff[2:0]];
   assign acc_next    = acc_ff + step_ff;
   assign fill_lhs    = bfdh_pkg::SAT_W'(count_ff) * bfdh_pkg::SAT_W'(bfdh_pkg::PERCENT);
   assign fill_rhs    = bfdh_pkg::SAT_W'(mod_ff) * bfdh_pkg::SAT_W'(fill_limit_ff);

   assign ram_rd_addr = rem_ff[3 +: bfdh_pkg::BYTE_AW];

   always_comb begin
      state_in         = state_ff;
      filter_bits_in   = filter_bits_ff;
      probe_count_in   = probe_count_ff;
      fill_limit_in    = fill_limit_ff;
      cmd_in           = cmd_ff;
      count_in         = count_ff;
      sweep_addr_in    = sweep_addr_ff;
      rsp_valid_in     = rsp_valid_ff;
      mod_in           = mod_ff;
      acc_in           = acc_ff;
      step_in          = step_ff;
      dividend_in      = dividend_ff;
      rem_in           = rem_ff;
      div_cnt_in       = div_cnt_ff;
      probe_idx_in     = probe_idx_ff;
      present_in       = present_ff;
      rsp_present_in   = rsp_present_ff;
      rsp_saturated_in = rsp_saturated_ff;
      rsp_count_in     = rsp_count_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = rem_ff[3 +: bfdh_pkg::BYTE_AW];
      ram_wr_data      = '0;
      ram_rd_en        = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            bfdh_pkg::CSR_FILTER_BITS: filter_bits_in = csr_wdata[FW-1:0];
            bfdh_pkg::CSR_PROBE_COUNT: probe_count_in = csr_wdata[bfdh_pkg::PROBE_W-1:0];
            bfdh_pkg::CSR_FILL_LIMIT:  fill_limit_in  = csr_wdata[bfdh_pkg::FILL_W-1:0];
            default: ;
         endcase
      end

      // retire the held result word
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bfdh_pkg::ST_SWEEP: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = sweep_addr_ff;
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == bfdh_pkg::BYTE_AW'(bfdh_pkg::STORE_BYTES - 1)) begin
               state_in = (cmd_ff == bfdh_pkg::CMD_CLEAR) ? bfdh_pkg::ST_FINISH
                                                          : bfdh_pkg::ST_IDLE;
            end
         end
         bfdh_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_command;
               acc_in       = req_first_hash;
               dividend_in  = req_first_hash;
               step_in      = step_hash + 32'd1;
               mod_in       = active_bits;
               rem_in       = '0;
               div_cnt_in   = '0;
               probe_idx_in = '0;
               present_in   = probing_on;
               unique case (req_command) inside
                  bfdh_pkg::CMD_ADD, bfdh_pkg::CMD_QUERY: begin
                     state_in = probing_on ? bfdh_pkg::ST_DIVIDE : bfdh_pkg::ST_FINISH;
                  end
                  bfdh_pkg::CMD_CLEAR: begin
                     count_in      = '0;
                     sweep_addr_in = '0;
                     state_in      = bfdh_pkg::ST_SWEEP;
                  end
                  default: state_in = bfdh_pkg::ST_FINISH;
               endcase
            end
         end
         bfdh_pkg::ST_DIVIDE: begin
            rem_in      = rem_step(rem_half, dividend_ff[HW-2], mod_ff);
            dividend_in = {dividend_ff[HW-3:0], 2'b00};
            div_cnt_in  = div_cnt_ff + 1'b1;
            if (div_cnt_ff == bfdh_pkg::DIV_CW'(bfdh_pkg::DIV_STEPS - 1)) begin
               state_in = bfdh_pkg::ST_READ;
            end
         end
         bfdh_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = bfdh_pkg::ST_UPDATE;
         end
         bfdh_pkg::ST_UPDATE: begin
            if (cmd_ff == bfdh_pkg::CMD_ADD && !bit_hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | (8'd1 << rem_ff[2:0]);
               count_in    = count_ff + 1'b1;
            end
            if (cmd_ff == bfdh_pkg::CMD_QUERY && !bit_hit) begin
               // one clear bit settles the query
               present_in = 1'b0;
               state_in   = bfdh_pkg::ST_FINISH;
            end else if ((probe_idx_ff + 6'd1) == probe_count_ff) begin
               state_in = bfdh_pkg::ST_FINISH;
            end else begin
               acc_in       = acc_next;
               dividend_in  = acc_next;
               step_in      = step_ff + 32'd2;
               probe_idx_in = probe_idx_ff + 6'd1;
               rem_in       = '0;
               div_cnt_in   = '0;
               state_in     = bfdh_pkg::ST_DIVIDE;
            end
         end
         bfdh_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_present_in   = present_ff && (cmd_ff == bfdh_pkg::CMD_QUERY);
               rsp_saturated_in = (mod_ff == '0) || (fill_lhs >= fill_rhs);
               rsp_count_in     = count_ff;
               state_in         = bfdh_pkg::ST_IDLE;
            end
         end
         default: state_in = bfdh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bfdh_pkg::ST_SWEEP;
         filter_bits_ff <= bfdh_pkg::FILTER_BITS_RESET;
         probe_count_ff <= bfdh_pkg::PROBE_COUNT_RESET;
         fill_limit_ff  <= bfdh_pkg::FILL_LIMIT_RESET;
         cmd_ff         <= bfdh_pkg::CMD_ADD;
         count_ff       <= '0;
         sweep_addr_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         filter_bits_ff <= filter_bits_in;
         probe_count_ff <= probe_count_in;
         fill_limit_ff  <= fill_limit_in;
         cmd_ff         <= cmd_in;
         count_ff       <= count_in;
         sweep_addr_ff  <= sweep_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff           <= mod_in;
      acc_ff           <= acc_in;
      step_ff          <= step_in;
      dividend_ff      <= dividend_in;
      rem_ff           <= rem_in;
      div_cnt_ff       <= div_cnt_in;
      probe_idx_ff     <= probe_idx_in;
      present_ff       <= present_in;
      rsp_present_ff   <= rsp_present_in;
      rsp_saturated_ff <= rsp_saturated_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign req_stall         = (state_ff != bfdh_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_present       = rsp_present_ff;
   assign rsp_saturated     = rsp_saturated_ff;
   assign rsp_set_bit_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bfdh_pkg::COUNT_W'(bfdh_pkg::STORE_BITS))
      else $error("ones count exceeds store size");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfdh_pkg::ST_READ |-> rem_ff < mod_ff)
      else $error("probe position not below modulus");

   a_write_on_add: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == bfdh_pkg::ST_UPDATE) |-> cmd_ff == bfdh_pkg::CMD_ADD)
      else $error("bit store written outside an add");

   a_sweep_count_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfdh_pkg::ST_SWEEP |-> count_ff == '0)
      else $error("ones count nonzero during clear sweep");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bfdh_pkg::ST_FINISH))
      else $error("result word raised outside finish");

endmodule
